// ===== design/tts_pkg.sv =====
`default_nettype none
package tts_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int COUNT_BITS_DEF = 8;
    localparam int MAX_SLOTS      = 8;
    localparam int SLOT_IDX_BITS  = 3;
    localparam int CFG_WIDTH      = 64;
    localparam int CFG_IDX_BITS   = 2;
    localparam int IN_WIDTH       = 16;
    localparam int OUT_WIDTH      = 24;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_STOP   = 3'd2;
    localparam logic [2:0] MODE_FINISH = 3'd3;
    localparam logic [2:0] MODE_PICK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SLOT_IDS     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOT_PERIODS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CYCLIC_MASK  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HANDLER_MASK = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

// ===== design/tts_ctrl.sv =====
`default_nettype none
module tts_ctrl
    import tts_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_s_tvalid,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    input  wire       i_m_tready,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        o_cmd.load = o_s_tready && i_s_tvalid;
        // update only once the output register can take the result
        o_cmd.exec = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/tts_datapath.sv =====
`default_nettype none
module tts_datapath
    import tts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire  [CFG_WIDTH-1:0]    i_cfg_data,
    input  wire  [IN_WIDTH-1:0]     i_item,
    input  wire  t_ctrl_cmd         i_cmd,
    output logic [OUT_WIDTH-1:0]    o_result
);

    localparam logic [SLOT_IDX_BITS:0] SLOTS = (SLOT_IDX_BITS+1)'(SLOT_COUNT);

    logic [CFG_WIDTH-1:0] r_ids, r_periods;
    logic [MAX_SLOTS-1:0] r_cyclic, r_handler;

    logic                     r_on     [SLOT_COUNT];
    logic [COUNT_BITS-1:0]    r_count  [SLOT_COUNT];
    logic [1:0]               r_status [SLOT_COUNT];
    logic [SLOT_IDX_BITS-1:0] r_last;

    logic                     n_on     [SLOT_COUNT];
    logic [COUNT_BITS-1:0]    n_count  [SLOT_COUNT];
    logic [1:0]               n_status [SLOT_COUNT];
    logic [SLOT_IDX_BITS-1:0] n_last;

    logic [IN_WIDTH-1:0]  r_item;
    logic [OUT_WIDTH-1:0] r_result, n_result;

    logic [2:0]               mode;
    logic [7:0]               task_id;
    logic [SLOT_IDX_BITS-1:0] done_slot;
    logic [1:0]               ret_status;

    logic                     found;
    logic [SLOT_IDX_BITS-1:0] found_idx;
    logic                     gvalid;
    logic [SLOT_IDX_BITS-1:0] grant;
    logic [SLOT_IDX_BITS:0]   cand;
    logic [MAX_SLOTS-1:0]     ready_mask, error_mask;

    assign mode       = r_item[2:0];
    assign task_id    = r_item[10:3];
    assign done_slot  = r_item[13:11];
    assign ret_status = r_item[15:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids     <= '0;
            r_periods <= '0;
            r_cyclic  <= '0;
            r_handler <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SLOT_IDS:     r_ids     <= i_cfg_data;
                REG_SLOT_PERIODS: r_periods <= i_cfg_data;
                REG_CYCLIC_MASK:  r_cyclic  <= i_cfg_data[MAX_SLOTS-1:0];
                REG_HANDLER_MASK: r_handler <= i_cfg_data[MAX_SLOTS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // lowest-numbered matching slot wins
        found     = 1'b0;
        found_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_ids[8*i +: 8] == task_id) begin
                found     = 1'b1;
                found_idx = SLOT_IDX_BITS'(i);
            end
        end

        // round-robin after the last grant, nearest candidate assigned last
        gvalid = 1'b0;
        grant  = '0;
        cand   = '0;
        for (int k = SLOT_COUNT; k >= 1; k--) begin
            cand = {1'b0, r_last} + (SLOT_IDX_BITS+1)'(k);
            if (cand >= SLOTS) begin
                cand = cand - SLOTS;
            end
            if (r_status[cand[SLOT_IDX_BITS-1:0]] == ST_READY
                    && r_handler[cand[SLOT_IDX_BITS-1:0]]) begin
                gvalid = 1'b1;
                grant  = cand[SLOT_IDX_BITS-1:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_on[i]     = r_on[i];
            n_count[i]  = r_count[i];
            n_status[i] = r_status[i];
        end
        n_last = r_last;

        case (mode)
            MODE_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (r_on[i] && r_status[i] != ST_READY) begin
                        if (r_count[i] != '0) begin
                            n_count[i] = r_count[i] - COUNT_BITS'(1);
                        end
                        if (n_count[i] == '0) begin
                            n_status[i] = ST_READY;
                        end
                    end
                end
            end
            MODE_START: begin
                if (found) begin
                    n_on[found_idx]    = 1'b1;
                    n_count[found_idx] = r_periods[8*found_idx +: COUNT_BITS];
                end
            end
            MODE_STOP: begin
                if (found) begin
                    n_on[found_idx]    = 1'b0;
                    n_count[found_idx] = '0;
                end
            end
            MODE_FINISH: begin
                if ({1'b0, done_slot} < SLOTS) begin
                    n_status[done_slot] = (ret_status == ST_BAD) ? ST_ERROR : ret_status;
                    if (r_cyclic[done_slot]) begin
                        n_count[done_slot] = r_periods[8*done_slot +: COUNT_BITS];
                    end else begin
                        n_on[done_slot] = 1'b0;
                    end
                end
            end
            MODE_PICK: begin
                if (gvalid) begin
                    n_last = grant;
                end
            end
            default: ;
        endcase

        ready_mask = '0;
        error_mask = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            ready_mask[i] = (n_status[i] == ST_READY);
            error_mask[i] = (n_status[i] == ST_ERROR);
        end

        n_result = {3'b000,
                    (mode == MODE_START || mode == MODE_STOP) && found,
                    (mode == MODE_PICK) && gvalid,
                    ((mode == MODE_PICK) && gvalid) ? grant : SLOT_IDX_BITS'(0),
                    error_mask,
                    ready_mask};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_on[i]     <= 1'b0;
                r_count[i]  <= '0;
                r_status[i] <= ST_OK;
            end
            r_last <= SLOT_IDX_BITS'(SLOT_COUNT - 1);
        end else if (i_cmd.exec) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_on[i]     <= n_on[i];
                r_count[i]  <= n_count[i];
                r_status[i] <= n_status[i];
            end
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== design/tick_task_ready_scheduler_top.sv =====
// the controller runs a capture then update sequence: the accepted item is
// registered, then the update step writes the result register; no new item is
// accepted until the update is done, and a held result stalls the update step
// reset (synchronous, active low): all slots off, counts zero, status ok,
// last grant at the highest slot, handler mask all ones, other config registers zero
`default_nettype none
module tick_task_ready_scheduler_top
    import tts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire  [CFG_WIDTH-1:0]    i_cfg_data,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    // mode[2:0], task_id[10:3], done_slot[13:11], returned_status[15:14]
    input  wire  [IN_WIDTH-1:0]     i_s_tdata,
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    // ready_mask[7:0], error_mask[15:8], grant_slot[18:16], grant_valid[19],
    // id_found[20], zero pad[23:21]
    output logic [OUT_WIDTH-1:0]    o_m_tdata
);

    t_ctrl_cmd cmd;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    tts_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_s_tdata),
        .i_cmd      (cmd),
        .o_result   (o_m_tdata)
    );

endmodule
`default_nettype wire
